### design/mwsm_pkg.sv
// Shared types, codes and the preset sign table for the mecanum wheel speed mixer.
package mwsm_pkg;

  localparam int NumWheels = 4;
  localparam int SpeedW    = 8;
  localparam int SumW      = 17;
  localparam int SpanProdW = 29;
  localparam int NumW      = 30;
  localparam int RadiusW   = 10;
  localparam int DimW      = 12;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 2;
  localparam logic [SpeedW-1:0] SpeedSat = 8'd255;

  typedef enum logic [3:0] {
    OP_VELOCITY   = 4'd0,
    OP_FWD        = 4'd1,
    OP_BACK       = 4'd2,
    OP_LEFT       = 4'd3,
    OP_RIGHT      = 4'd4,
    OP_FWD_RIGHT  = 4'd5,
    OP_FWD_LEFT   = 4'd6,
    OP_BACK_RIGHT = 4'd7,
    OP_BACK_LEFT  = 4'd8,
    OP_TURN_RIGHT = 4'd9,
    OP_TURN_LEFT  = 4'd10,
    OP_STOP       = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_BACK = 2'd1,
    DIR_REL  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_SPEED  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WS_ZERO = 2'd0,
    WS_POS  = 2'd1,
    WS_NEG  = 2'd2
  } wsign_t;

  // index 0 FL, 1 FR, 2 RL, 3 RR
  typedef wsign_t [NumWheels-1:0] wsign4_t;

  typedef struct packed {
    logic [DimW-1:0]    body_width;
    logic [DimW-1:0]    body_length;
    logic [RadiusW-1:0] wheel_radius;
    logic [SpeedW-1:0]  default_speed;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                         op;
    logic signed [SumW-1:0]      sum_xy;
    logic signed [SumW-1:0]      diff_xy;
    logic signed [SpanProdW-1:0] w_span;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [NumWheels-1:0][SpeedW-1:0] speed;
    dir_t [NumWheels-1:0]             dir;
  } res_t;

  function automatic wsign4_t preset_signs(op_t op);
    wsign4_t s;
    unique case (op)
      OP_FWD:        s = {WS_POS,  WS_POS,  WS_POS,  WS_POS};
      OP_BACK:       s = {WS_NEG,  WS_NEG,  WS_NEG,  WS_NEG};
      OP_LEFT:       s = {WS_NEG,  WS_POS,  WS_POS,  WS_NEG};
      OP_RIGHT:      s = {WS_POS,  WS_NEG,  WS_NEG,  WS_POS};
      OP_FWD_RIGHT:  s = {WS_ZERO, WS_POS,  WS_POS,  WS_ZERO};
      OP_FWD_LEFT:   s = {WS_POS,  WS_ZERO, WS_ZERO, WS_POS};
      OP_BACK_RIGHT: s = {WS_NEG,  WS_ZERO, WS_ZERO, WS_NEG};
      OP_BACK_LEFT:  s = {WS_ZERO, WS_NEG,  WS_NEG,  WS_ZERO};
      OP_TURN_RIGHT: s = {WS_NEG,  WS_POS,  WS_NEG,  WS_POS};
      OP_TURN_LEFT:  s = {WS_POS,  WS_NEG,  WS_POS,  WS_NEG};
      default:       s = {WS_ZERO, WS_ZERO, WS_ZERO, WS_ZERO};
    endcase
    return s;
  endfunction

endpackage

### design/mecanum_wheel_speed_mixer.sv
// Top level of the mecanum wheel speed mixer: config registers, front, queue and back.
// Throughput: one command per cycle when unstalled, set by the front and back register stages.
// Output stall reaches in_stall once the queue is full; input resumes the cycle after output.
// Reset (synchronous, rst_n low): pipeline and queue empty, width 0, length 0,
// radius 30, default speed 128.
module mecanum_wheel_speed_mixer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [11:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_operation,
  input  logic signed [15:0]   in_x_velocity,
  input  logic                 in_x_present,
  input  logic signed [15:0]   in_y_velocity,
  input  logic                 in_y_present,
  input  logic signed [15:0]   in_angular_rate,
  input  logic                 in_angular_present,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_speed_front_left,
  output logic [7:0]           out_speed_front_right,
  output logic [7:0]           out_speed_rear_left,
  output logic [7:0]           out_speed_rear_right,
  output logic [1:0]           out_dir_front_left,
  output logic [1:0]           out_dir_front_right,
  output logic [1:0]           out_dir_rear_left,
  output logic [1:0]           out_dir_rear_right
);

  mwsm_pkg::cfg_t     cfg_r, cfg_nxt;
  mwsm_pkg::q_stat_t  q_stat;
  mwsm_pkg::cmd_t     push_cmd;
  mwsm_pkg::cmd_t     head;
  mwsm_pkg::res_t     res;
  logic               push, pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (mwsm_pkg::cfg_idx_t'(cfg_index))
        mwsm_pkg::CFG_WIDTH:  cfg_nxt.body_width    = cfg_wdata[mwsm_pkg::DimW-1:0];
        mwsm_pkg::CFG_LENGTH: cfg_nxt.body_length   = cfg_wdata[mwsm_pkg::DimW-1:0];
        mwsm_pkg::CFG_RADIUS: cfg_nxt.wheel_radius  = cfg_wdata[mwsm_pkg::RadiusW-1:0];
        mwsm_pkg::CFG_SPEED:  cfg_nxt.default_speed = cfg_wdata[mwsm_pkg::SpeedW-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.body_width    <= '0;
      cfg_r.body_length   <= '0;
      cfg_r.wheel_radius  <= mwsm_pkg::RadiusW'(30);
      cfg_r.default_speed <= mwsm_pkg::SpeedW'(128);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mwsm_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_x_velocity      (in_x_velocity),
    .in_x_present       (in_x_present),
    .in_y_velocity      (in_y_velocity),
    .in_y_present       (in_y_present),
    .in_angular_rate    (in_angular_rate),
    .in_angular_present (in_angular_present),
    .cfg                (cfg_r),
    .q_stat             (q_stat),
    .push               (push),
    .push_cmd           (push_cmd)
  );

  mwsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  mwsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_speed_front_left  = res.speed[0];
  assign out_speed_front_right = res.speed[1];
  assign out_speed_rear_left   = res.speed[2];
  assign out_speed_rear_right  = res.speed[3];
  assign out_dir_front_left    = res.dir[0];
  assign out_dir_front_right   = res.dir[1];
  assign out_dir_rear_left     = res.dir[2];
  assign out_dir_rear_right    = res.dir[3];

endmodule

### design/mwsm_front.sv
// Front stage: accepts commands, classifies the operation and forms x+-y and w*(W+L).
module mwsm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            in_operation,
  input  logic signed [15:0]    in_x_velocity,
  input  logic                  in_x_present,
  input  logic signed [15:0]    in_y_velocity,
  input  logic                  in_y_present,
  input  logic signed [15:0]    in_angular_rate,
  input  logic                  in_angular_present,
  input  mwsm_pkg::cfg_t        cfg,
  input  mwsm_pkg::q_stat_t     q_stat,
  output logic                  push,
  output mwsm_pkg::cmd_t        push_cmd
);

  logic                                 vld_r, vld_nxt;
  mwsm_pkg::cmd_t                       cmd_r;
  mwsm_pkg::cmd_t                       cmd_nxt;
  logic signed [15:0]                   x, y, w;
  logic [mwsm_pkg::DimW:0]              span;
  logic signed [mwsm_pkg::NumW-1:0]     prod;
  logic                                 take;

  assign in_stall = vld_r && q_stat.full;
  assign take     = in_valid && !in_stall;
  assign push     = vld_r && !q_stat.full;
  assign push_cmd = cmd_r;

  always_comb begin
    x    = in_x_present       ? in_x_velocity   : 16'sd0;
    y    = in_y_present       ? in_y_velocity   : 16'sd0;
    w    = in_angular_present ? in_angular_rate : 16'sd0;
    span = {1'b0, cfg.body_width} + {1'b0, cfg.body_length};
    prod = w * $signed({1'b0, span});
    cmd_nxt.op      = (in_operation > mwsm_pkg::OP_STOP) ? mwsm_pkg::OP_STOP
                                                         : mwsm_pkg::op_t'(in_operation);
    cmd_nxt.sum_xy  = {x[15], x} + {y[15], y};
    cmd_nxt.diff_xy = {x[15], x} - {y[15], y};
    cmd_nxt.w_span  = prod[mwsm_pkg::SpanProdW-1:0];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

### design/mwsm_queue.sv
// Two-entry command queue between the front and back stages.
module mwsm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mwsm_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output mwsm_pkg::cmd_t     head,
  output mwsm_pkg::q_stat_t  stat
);

  mwsm_pkg::cmd_t ent_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign head       = ent_r[rptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_cmd;
    end
  end

endmodule

### design/mwsm_back.sv
// Back stage: per-wheel threshold test or preset lookup, with the output register.
module mwsm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mwsm_pkg::cfg_t     cfg,
  input  mwsm_pkg::q_stat_t  q_stat,
  input  mwsm_pkg::cmd_t     head,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output mwsm_pkg::res_t     res
);

  logic                               vld_r, vld_nxt;
  mwsm_pkg::res_t                     res_r;
  mwsm_pkg::res_t                     res_nxt;
  logic [mwsm_pkg::RadiusW-1:0]       radius;
  logic [mwsm_pkg::NumW-1:0]          thresh;
  logic signed [mwsm_pkg::NumW-1:0]   base [mwsm_pkg::NumWheels];
  logic signed [mwsm_pkg::NumW-1:0]   num  [mwsm_pkg::NumWheels];
  logic [mwsm_pkg::NumW-1:0]          mag  [mwsm_pkg::NumWheels];
  logic signed [mwsm_pkg::NumW-1:0]   wsx;
  mwsm_pkg::wsign4_t                  ps;

  assign pop       = !q_stat.empty && (!vld_r || !out_stall);
  assign out_valid = vld_r;
  assign res       = res_r;

  always_comb begin
    radius = (cfg.wheel_radius == '0) ? mwsm_pkg::RadiusW'(1) : cfg.wheel_radius;
    thresh = {{(mwsm_pkg::NumW-mwsm_pkg::RadiusW-8){1'b0}}, radius, 8'b0};
    wsx    = {head.w_span[mwsm_pkg::SpanProdW-1], head.w_span};
    // FL: x+y-wT, FR: x-y+wT, RL: x-y-wT, RR: x+y+wT
    base[0] = {{5{head.sum_xy[mwsm_pkg::SumW-1]}},  head.sum_xy,  8'b0};
    base[1] = {{5{head.diff_xy[mwsm_pkg::SumW-1]}}, head.diff_xy, 8'b0};
    base[2] = base[1];
    base[3] = base[0];
    num[0]  = base[0] - wsx;
    num[1]  = base[1] + wsx;
    num[2]  = base[2] - wsx;
    num[3]  = base[3] + wsx;
    ps      = mwsm_pkg::preset_signs(head.op);
    for (int k = 0; k < mwsm_pkg::NumWheels; k++) begin
      mag[k] = num[k][mwsm_pkg::NumW-1] ? -num[k] : num[k];
      if (head.op == mwsm_pkg::OP_VELOCITY) begin
        if (mag[k] >= thresh) begin
          res_nxt.speed[k] = mwsm_pkg::SpeedSat;
          res_nxt.dir[k]   = num[k][mwsm_pkg::NumW-1] ? mwsm_pkg::DIR_BACK
                                                      : mwsm_pkg::DIR_FWD;
        end else begin
          res_nxt.speed[k] = '0;
          res_nxt.dir[k]   = mwsm_pkg::DIR_REL;
        end
      end else if (ps[k] == mwsm_pkg::WS_ZERO || cfg.default_speed == '0) begin
        res_nxt.speed[k] = '0;
        res_nxt.dir[k]   = mwsm_pkg::DIR_REL;
      end else begin
        res_nxt.speed[k] = cfg.default_speed;
        res_nxt.dir[k]   = (ps[k] == mwsm_pkg::WS_NEG) ? mwsm_pkg::DIR_BACK
                                                       : mwsm_pkg::DIR_FWD;
      end
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (pop) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

### design/mwsm_checker.sv
// Port-level checker for the mecanum wheel speed mixer, bound to the top level.
module mwsm_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_speed_front_left,
  input logic [7:0]  out_speed_front_right,
  input logic [7:0]  out_speed_rear_left,
  input logic [7:0]  out_speed_rear_right,
  input logic [1:0]  out_dir_front_left,
  input logic [1:0]  out_dir_front_right,
  input logic [1:0]  out_dir_rear_left,
  input logic [1:0]  out_dir_rear_right
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_speed_front_left)
      && $stable(out_dir_rear_right))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_dir_front_left  == mwsm_pkg::DIR_REL) == (out_speed_front_left  == 8'd0)) &&
      ((out_dir_front_right == mwsm_pkg::DIR_REL) == (out_speed_front_right == 8'd0)) &&
      ((out_dir_rear_left   == mwsm_pkg::DIR_REL) == (out_speed_rear_left   == 8'd0)) &&
      ((out_dir_rear_right  == mwsm_pkg::DIR_REL) == (out_speed_rear_right  == 8'd0)))
    else $error("release direction and zero speed disagree");

  a_front_rear_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_dir_front_left == mwsm_pkg::DIR_REL) == (out_dir_rear_right == mwsm_pkg::DIR_REL))
      || (out_speed_front_left == 8'd255) || (out_speed_rear_right == 8'd255))
    else $error("diagonal wheel pair inconsistent");

endmodule

bind mecanum_wheel_speed_mixer mwsm_port_checker u_mwsm_port_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_speed_front_left  (out_speed_front_left),
  .out_speed_front_right (out_speed_front_right),
  .out_speed_rear_left   (out_speed_rear_left),
  .out_speed_rear_right  (out_speed_rear_right),
  .out_dir_front_left    (out_dir_front_left),
  .out_dir_front_right   (out_dir_front_right),
  .out_dir_rear_left     (out_dir_rear_left),
  .out_dir_rear_right    (out_dir_rear_right)
);

### tb/mwsm_checker.sv
// Checker for the mecanum wheel speed mixer: tracks config writes, predicts wheel commands, compares results.
module mwsm_checker
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_operation,
  input  logic signed [15:0] in_x_velocity,
  input  logic               in_x_present,
  input  logic signed [15:0] in_y_velocity,
  input  logic               in_y_present,
  input  logic signed [15:0] in_angular_rate,
  input  logic               in_angular_present,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_speed_front_left,
  input  logic [7:0]         out_speed_front_right,
  input  logic [7:0]         out_speed_rear_left,
  input  logic [7:0]         out_speed_rear_right,
  input  logic [1:0]         out_dir_front_left,
  input  logic [1:0]         out_dir_front_right,
  input  logic [1:0]         out_dir_rear_left,
  input  logic [1:0]         out_dir_rear_right,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // wheel k: 0 front left, 1 front right, 2 rear left, 3 rear right
  typedef struct packed {
    logic [3:0][7:0] speed;
    logic [3:0][1:0] dir;
  } wheel_set_t;

  logic [11:0] width_mm;
  logic [11:0] length_mm;
  logic [9:0]  radius_mm;
  logic [7:0]  cruise_speed;
  wheel_set_t  wheel_cmds_due[$];
  wheel_set_t  seen;
  wheel_set_t  want;
  string       wheel_tag[4] = '{"front_left", "front_right", "rear_left", "rear_right"};

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic wheel_set_t mix_wheels(logic [3:0] opcode,
                                            logic signed [15:0] xin, logic xp,
                                            logic signed [15:0] yin, logic yp,
                                            logic signed [15:0] win, logic wp);
    wheel_set_t ws;
    op_t        op;
    longint     xv, yv, wv, span, rad, num, q, v;
    int         ysg[4] = '{1, -1, -1, 1};
    int         wsg[4] = '{-1, 1, -1, 1};
    int         ps[4];
    op   = (opcode > OP_STOP) ? OP_STOP : op_t'(opcode);
    xv   = xp ? longint'(xin) : 0;
    yv   = yp ? longint'(yin) : 0;
    wv   = wp ? longint'(win) : 0;
    span = longint'(width_mm) + longint'(length_mm);
    rad  = (radius_mm == 0) ? 1 : longint'(radius_mm);
    case (op)
      OP_FWD:        ps = '{1, 1, 1, 1};
      OP_BACK:       ps = '{-1, -1, -1, -1};
      OP_LEFT:       ps = '{-1, 1, 1, -1};
      OP_RIGHT:      ps = '{1, -1, -1, 1};
      OP_FWD_RIGHT:  ps = '{0, 1, 1, 0};
      OP_FWD_LEFT:   ps = '{1, 0, 0, 1};
      OP_BACK_RIGHT: ps = '{-1, 0, 0, -1};
      OP_BACK_LEFT:  ps = '{0, -1, -1, 0};
      OP_TURN_RIGHT: ps = '{1, -1, 1, -1};
      OP_TURN_LEFT:  ps = '{-1, 1, -1, 1};
      default:       ps = '{0, 0, 0, 0};
    endcase
    for (int k = 0; k < 4; k++) begin
      if (op == OP_VELOCITY) begin
        // Q8.8 numerator, truncating divide, then gain and clamp
        num = 256 * (xv + ysg[k] * yv) + wsg[k] * wv * span;
        q   = num / (256 * rad);
        v   = q * 1000;
        if (v > 255) v = 255;
        if (v < -255) v = -255;
      end else begin
        v = ps[k] * longint'(cruise_speed);
      end
      if (v > 0) begin
        ws.speed[k] = 8'(v);
        ws.dir[k]   = DIR_FWD;
      end else if (v < 0) begin
        ws.speed[k] = 8'(-v);
        ws.dir[k]   = DIR_BACK;
      end else begin
        ws.speed[k] = 8'd0;
        ws.dir[k]   = DIR_REL;
      end
    end
    return ws;
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_mm     = '0;
      length_mm    = '0;
      radius_mm    = 10'd30;
      cruise_speed = 8'd128;
      wheel_cmds_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.speed = {out_speed_rear_right, out_speed_rear_left,
                      out_speed_front_right, out_speed_front_left};
        seen.dir   = {out_dir_rear_right, out_dir_rear_left,
                      out_dir_front_right, out_dir_front_left};
        if (wheel_cmds_due.size() == 0) begin
          flag_mismatch("transaction with nothing pending", seen.speed[0], 8'd0);
        end else begin
          want = wheel_cmds_due.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (seen.speed[k] !== want.speed[k])
              flag_mismatch({"speed_", wheel_tag[k]}, seen.speed[k], want.speed[k]);
            if (seen.dir[k] !== want.dir[k])
              flag_mismatch({"dir_", wheel_tag[k]}, 8'(seen.dir[k]), 8'(want.dir[k]));
          end
        end
      end
      if (in_valid && !in_stall)
        wheel_cmds_due.push_back(mix_wheels(in_operation, in_x_velocity, in_x_present,
                                            in_y_velocity, in_y_present,
                                            in_angular_rate, in_angular_present));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width_mm     = cfg_wdata;
          CFG_LENGTH: length_mm    = cfg_wdata;
          CFG_RADIUS: radius_mm    = cfg_wdata[9:0];
          CFG_SPEED:  cruise_speed = cfg_wdata[7:0];
          default:    ;
        endcase
      end
    end
    pending = wheel_cmds_due.size();
  end

endmodule

### tb/tb_mecanum_wheel_speed_mixer.sv
// Testbench top for the mecanum wheel speed mixer: clock, reset, stimulus, stalls and verdict.
module tb_mecanum_wheel_speed_mixer;
  import mwsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int          PhaseItems = 130;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [15:0] x;
    logic               xp;
    logic signed [15:0] y;
    logic               yp;
    logic signed [15:0] w;
    logic               wp;
  } drive_cmd_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [11:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_operation;
  logic signed [15:0] in_x_velocity;
  logic               in_x_present;
  logic signed [15:0] in_y_velocity;
  logic               in_y_present;
  logic signed [15:0] in_angular_rate;
  logic               in_angular_present;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_speed_front_left;
  logic [7:0]         out_speed_front_right;
  logic [7:0]         out_speed_rear_left;
  logic [7:0]         out_speed_rear_right;
  logic [1:0]         out_dir_front_left;
  logic [1:0]         out_dir_front_right;
  logic [1:0]         out_dir_rear_left;
  logic [1:0]         out_dir_rear_right;
  int                 fail_count;
  int                 pending;

  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          cur_span = 0;
  int          cur_radius = 30;
  int unsigned cycles = 0;

  mecanum_wheel_speed_mixer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_x_velocity         (in_x_velocity),
    .in_x_present          (in_x_present),
    .in_y_velocity         (in_y_velocity),
    .in_y_present          (in_y_present),
    .in_angular_rate       (in_angular_rate),
    .in_angular_present    (in_angular_present),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_speed_front_left  (out_speed_front_left),
    .out_speed_front_right (out_speed_front_right),
    .out_speed_rear_left   (out_speed_rear_left),
    .out_speed_rear_right  (out_speed_rear_right),
    .out_dir_front_left    (out_dir_front_left),
    .out_dir_front_right   (out_dir_front_right),
    .out_dir_rear_left     (out_dir_rear_left),
    .out_dir_rear_right    (out_dir_rear_right)
  );

  mwsm_checker mixer_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_x_velocity         (in_x_velocity),
    .in_x_present          (in_x_present),
    .in_y_velocity         (in_y_velocity),
    .in_y_present          (in_y_present),
    .in_angular_rate       (in_angular_rate),
    .in_angular_present    (in_angular_present),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_speed_front_left  (out_speed_front_left),
    .out_speed_front_right (out_speed_front_right),
    .out_speed_rear_left   (out_speed_rear_left),
    .out_speed_rear_right  (out_speed_rear_right),
    .out_dir_front_left    (out_dir_front_left),
    .out_dir_front_right   (out_dir_front_right),
    .out_dir_rear_left     (out_dir_rear_left),
    .out_dir_rear_right    (out_dir_rear_right),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic drive_cmd_t make_cmd(logic [3:0] op, int x, bit xp, int y, bit yp,
                                          int w, bit wp);
    drive_cmd_t c;
    c.op = op;
    c.x  = x[15:0];
    c.xp = xp;
    c.y  = y[15:0];
    c.yp = yp;
    c.w  = w[15:0];
    c.wp = wp;
    return c;
  endfunction

  function automatic logic [15:0] pick_value(int bound);
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4, 5: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2 * bound)) - bound);
    endcase
  endfunction

  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    int         lin_bound;
    int         ang_bound;
    int         rad;
    rad       = (cur_radius == 0) ? 1 : cur_radius;
    lin_bound = (2 * rad > 32767) ? 32767 : 2 * rad;
    ang_bound = (cur_span == 0) ? 512 : 512 * rad / cur_span + 2;
    if (ang_bound > 32767) ang_bound = 32767;
    c.op = ($urandom_range(0, 1) != 0) ? 4'(OP_VELOCITY) : 4'($urandom_range(1, 15));
    c.x  = pick_value(lin_bound);
    c.y  = pick_value(lin_bound);
    if ($urandom_range(0, 7) == 0)
      c.y = ($urandom_range(0, 1) != 0) ? c.x : -c.x;
    c.w  = pick_value(ang_bound);
    c.xp = ($urandom_range(0, 3) != 0);
    c.yp = ($urandom_range(0, 3) != 0);
    c.wp = ($urandom_range(0, 3) != 0);
    return c;
  endfunction

  task automatic offer_cmd(drive_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid           = 1'b1;
    in_operation       = c.op;
    in_x_velocity      = c.x;
    in_x_present       = c.xp;
    in_y_velocity      = c.y;
    in_y_present       = c.yp;
    in_angular_rate    = c.w;
    in_angular_present = c.wp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) offer_cmd(random_cmd());
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // unused upper data bits carry noise; the registers must ignore them
  task automatic apply_config(int wd, int ln, int rd, int sp);
    settle();
    write_reg(CFG_WIDTH, 12'(wd));
    write_reg(CFG_LENGTH, 12'(ln));
    write_reg(CFG_RADIUS, {2'($urandom), 10'(rd)});
    write_reg(CFG_SPEED, {4'($urandom), 8'(sp)});
    cur_span   = wd + ln;
    cur_radius = rd;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin : receiver
      stall_mode_t mode;
      int          mode_left;
      int          hold_left;
      int          beat;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      beat      = 0;
      forever begin
        @(negedge clk);
        beat++;
        if (hold_left > 0) begin
          hold_left--;
          out_stall = 1'b1;
        end else if (hold_seen != hold_req) begin
          hold_seen = hold_req;
          hold_left = 79;
          out_stall = 1'b1;
        end else begin
          if (mode_left == 0) begin
            mode      = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 60);
          end
          mode_left--;
          case (mode)
            STALL_NONE:  out_stall = 1'b0;
            STALL_COIN:  out_stall = ($urandom_range(0, 1) != 0);
            STALL_HEAVY: out_stall = ($urandom_range(0, 9) < 8);
            default:     out_stall = (beat % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_operation       = '0;
    in_x_velocity      = '0;
    in_x_present       = 1'b0;
    in_y_velocity      = '0;
    in_y_present       = 1'b0;
    in_angular_rate    = '0;
    in_angular_present = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every preset and the codes past stop, with junk velocity fields
    for (int op = 1; op < 16; op++)
      offer_cmd(make_cmd(4'(op), $urandom, 1, $urandom, 1, $urandom, 1));
    offer_cmd(make_cmd(OP_VELOCITY, 32767, 1, -32768, 1, 32767, 1));
    offer_cmd(make_cmd(OP_VELOCITY, -32768, 1, 32767, 1, -32768, 1));
    offer_cmd(make_cmd(OP_VELOCITY, 12345, 0, -999, 0, 700, 0));
    offer_cmd(make_cmd(OP_VELOCITY, 29, 1, 0, 1, 0, 0));
    offer_cmd(make_cmd(OP_VELOCITY, 30, 1, 0, 0, 0, 0));
    offer_cmd(make_cmd(OP_VELOCITY, -30, 1, 5, 0, 0, 0));
    offer_cmd(make_cmd(OP_VELOCITY, 100, 1, 100, 1, 0, 0));
    offer_cmd(make_cmd(OP_VELOCITY, 0, 0, -60, 1, 0, 0));

    run_random(40);
    hold_req++;
    burst_left = 200;
    run_random(PhaseItems - 40);

    apply_config(4095, 4095, 1023, 255);
    // rotation term just above and just below one radius step
    offer_cmd(make_cmd(OP_VELOCITY, 0, 0, 0, 0, 32, 1));
    offer_cmd(make_cmd(OP_VELOCITY, 0, 0, 0, 0, 31, 1));
    run_random(PhaseItems);

    apply_config(0, 0, 1, 0);
    run_random(PhaseItems);
    apply_config(0, 0, 0, 77);
    run_random(PhaseItems);
    apply_config(10, 20, 1023, 1);
    run_random(PhaseItems);
    repeat (3) begin
      apply_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(1, 1023), $urandom_range(0, 255));
      run_random(PhaseItems);
    end

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
